// ----- sv/volume_bilinear_nearest_resampler_defines.svh -----
// ----------------------------------------------------------------------------
// Resampler assertion macros
// Concurrent assertion wrappers, compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef VOLUME_BILINEAR_NEAREST_RESAMPLER_DEFINES_SVH
`define VOLUME_BILINEAR_NEAREST_RESAMPLER_DEFINES_SVH
`ifndef SYNTHESIS
`define VBNR_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define VBNR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define VBNR_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define VBNR_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ----- sv/vbnr_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Resampler package
// Shared constants and types of the volume resampler.
// ----------------------------------------------------------------------------
package vbnr_pkg;
    localparam int MaxDimX = 32;
    localparam int MaxDimY = 32;
    localparam int MaxDimZ = 32;
    localparam int XW = $clog2(MaxDimX);
    localparam int YW = $clog2(MaxDimY);
    localparam int ZW = $clog2(MaxDimZ);
    localparam int AW = XW + YW + ZW;

    localparam logic [2:0] REG_SIZE_X = 3'd0;
    localparam logic [2:0] REG_SIZE_Y = 3'd1;
    localparam logic [2:0] REG_SIZE_Z = 3'd2;
    localparam logic [2:0] REG_RATIO_X = 3'd3;
    localparam logic [2:0] REG_RATIO_Y = 3'd4;
    localparam logic [2:0] REG_RATIO_Z = 3'd5;
    localparam logic [2:0] REG_NEAREST = 3'd6;
    localparam logic [2:0] REG_LABEL = 3'd7;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_SAMPLE = 1'b1;

    // command handed from front to back
    typedef struct packed {
        logic          is_load;
        logic [AW-1:0] addr_ll;   // lo a, lo b
        logic [AW-1:0] addr_hl;   // hi a, lo b
        logic [AW-1:0] addr_lh;   // lo a, hi b
        logic [AW-1:0] addr_hh;   // hi a, hi b
        logic [15:0]   frac_a;
        logic [15:0]   frac_b;
        logic [15:0]   data;
        logic          label;
    } op_t;
endpackage

// ----- sv/vbnr_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Resampler front end
// Accepts transactions, scales coordinates and computes neighbor addresses.
// Two stages: multiply, then clamp and address.
// ----------------------------------------------------------------------------
`include "volume_bilinear_nearest_resampler_defines.svh"
module vbnr_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 valid,
    output logic                 stall,
    input  logic                 command,
    input  logic [7:0]           coord_x,
    input  logic [7:0]           coord_y,
    input  logic [7:0]           coord_z,
    input  logic signed [15:0]   voxel_in,
    input  logic [5:0]           src_size_x,
    input  logic [5:0]           src_size_y,
    input  logic [5:0]           src_size_z,
    input  logic [23:0]          ratio_x,
    input  logic [23:0]          ratio_y,
    input  logic [23:0]          ratio_z,
    input  logic [1:0]           nearest_axis,
    input  logic                 label_mode,
    output logic                 op_valid,
    output vbnr_pkg::op_t        op,
    input  logic                 op_stall
);
    // stage 1
    logic        s1_valid_reg;
    logic        s1_cmd_reg;
    logic [7:0]  s1_cx_reg, s1_cy_reg, s1_cz_reg;
    logic [31:0] s1_px_reg, s1_py_reg, s1_pz_reg;
    logic [15:0] s1_data_reg;
    // stage 2 (output)
    logic          s2_valid_reg;
    vbnr_pkg::op_t s2_op_reg;
    vbnr_pkg::op_t op_next;
    logic          adv2, adv1;

    assign adv2  = !s2_valid_reg || !op_stall;
    assign adv1  = !s1_valid_reg || adv2;
    assign stall = !adv1;

    always_ff @(posedge clk)
    begin
        if (adv1)
        begin
            s1_cmd_reg  <= command;
            s1_cx_reg   <= coord_x;
            s1_cy_reg   <= coord_y;
            s1_cz_reg   <= coord_z;
            s1_px_reg   <= coord_x * ratio_x;
            s1_py_reg   <= coord_y * ratio_y;
            s1_pz_reg   <= coord_z * ratio_z;
            s1_data_reg <= voxel_in;
        end
        if (adv2 && s1_valid_reg)
            s2_op_reg <= op_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            if (adv1)
                s1_valid_reg <= valid;
            if (adv2)
                s2_valid_reg <= s1_valid_reg;
        end
    end

    function automatic logic [5:0] eff_size(input logic [5:0] s, input int mx);
        logic [5:0] r;
        begin
            r = s;
            if (s == 6'd0)
                r = 6'd1;
            if ({26'd0, s} > mx)
                r = 6'(mx);
            return r;
        end
    endfunction

    // per-axis: lo, hi, frac
    logic [5:0]  sz   [3];
    logic [31:0] p    [3];
    logic [4:0]  lo   [3];
    logic [4:0]  hi   [3];
    logic [15:0] fr   [3];
    logic [1:0]  n;
    logic [17:0] rnd;
    logic [4:0]  cl [4][3];

    always_comb
    begin
        sz[0] = eff_size(src_size_x, vbnr_pkg::MaxDimX);
        sz[1] = eff_size(src_size_y, vbnr_pkg::MaxDimY);
        sz[2] = eff_size(src_size_z, vbnr_pkg::MaxDimZ);
        p[0] = s1_px_reg;
        p[1] = s1_py_reg;
        p[2] = s1_pz_reg;
        n = (nearest_axis == 2'd3) ? 2'd2 : nearest_axis;
        for (int ax = 0; ax < 3; ax++)
        begin
            rnd = 18'(({1'b0, p[ax]} + 33'h8000) >> 16);
            if (ax == int'(n))
            begin
                lo[ax] = (rnd > 18'(sz[ax] - 6'd1)) ? 5'(sz[ax] - 6'd1) : rnd[4:0];
                hi[ax] = lo[ax];
                fr[ax] = 16'd0;
            end
            else if (p[ax][31:16] >= 16'(sz[ax] - 6'd1))
            begin
                lo[ax] = 5'(sz[ax] - 6'd1);
                hi[ax] = lo[ax];
                fr[ax] = 16'd0;
            end
            else
            begin
                lo[ax] = p[ax][20:16];
                hi[ax] = 5'(p[ax][20:16] + 5'd1);
                fr[ax] = p[ax][15:0];
            end
        end
        // corner k: bit0 = a hi, bit1 = b hi
        for (int k = 0; k < 4; k++)
        begin
            for (int ax = 0; ax < 3; ax++)
            begin
                cl[k][ax] = lo[ax];
                if (ax == (int'(n) + 1) % 3 && k[0])
                    cl[k][ax] = hi[ax];
                if (ax == (int'(n) + 2) % 3 && k[1])
                    cl[k][ax] = hi[ax];
            end
        end
        op_next.is_load = (s1_cmd_reg == vbnr_pkg::CMD_LOAD);
        if (s1_cmd_reg == vbnr_pkg::CMD_LOAD)
            op_next.addr_ll = {s1_cx_reg[4:0], s1_cy_reg[4:0], s1_cz_reg[4:0]};
        else
            op_next.addr_ll = {cl[0][0], cl[0][1], cl[0][2]};
        op_next.addr_hl = {cl[1][0], cl[1][1], cl[1][2]};
        op_next.addr_lh = {cl[2][0], cl[2][1], cl[2][2]};
        op_next.addr_hh = {cl[3][0], cl[3][1], cl[3][2]};
        op_next.frac_a = fr[(int'(n) + 1) % 3];
        op_next.frac_b = fr[(int'(n) + 2) % 3];
        op_next.data = s1_data_reg;
        // on a load the label bit marks a load outside the store, which is dropped
        op_next.label = label_mode;
        if (s1_cmd_reg == vbnr_pkg::CMD_LOAD)
            op_next.label = (s1_cx_reg >= 8'(vbnr_pkg::MaxDimX)) ||
                            (s1_cy_reg >= 8'(vbnr_pkg::MaxDimY)) ||
                            (s1_cz_reg >= 8'(vbnr_pkg::MaxDimZ));
    end

    assign op_valid = s2_valid_reg;
    assign op       = s2_op_reg;

    `VBNR_ASSERT_NEXT(a_front_hold, clk, rst_n, op_valid && op_stall, op_valid && $stable(op))
    `VBNR_ASSERT_IMPL(a_front_stall, clk, rst_n, stall, s1_valid_reg && s2_valid_reg)
    `VBNR_ASSERT_NEXT(a_front_flow, clk, rst_n, s1_valid_reg && !stall, op_valid)
endmodule

// ----- sv/vbnr_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Resampler command queue
// Two-entry FIFO that decouples the front end from the back end.
// ----------------------------------------------------------------------------
`include "volume_bilinear_nearest_resampler_defines.svh"
module vbnr_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_stall,
    input  vbnr_pkg::op_t in_op,
    output logic          out_valid,
    input  logic          out_stall,
    output vbnr_pkg::op_t out_op
);
    vbnr_pkg::op_t ent_reg [2];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;
    logic       push, pop;

    assign in_stall  = (cnt_reg == 2'd2);
    assign out_valid = (cnt_reg != 2'd0);
    assign push      = in_valid && !in_stall;
    assign pop       = out_valid && !out_stall;
    assign out_op    = ent_reg[rp_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            ent_reg[wp_reg] <= in_op;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (push)
                wp_reg <= !wp_reg;
            if (pop)
                rp_reg <= !rp_reg;
            cnt_reg <= cnt_reg + 2'(push) - 2'(pop);
        end
    end

    `VBNR_ASSERT_IMPL(a_q_bound, clk, rst_n, 1'b1, cnt_reg != 2'd3)
    `VBNR_ASSERT_IMPL(a_q_ptr, clk, rst_n, cnt_reg == 2'd0 || cnt_reg == 2'd2, wp_reg == rp_reg)
    `VBNR_ASSERT_IMPL(a_q_ptr1, clk, rst_n, cnt_reg == 2'd1, wp_reg != rp_reg)
endmodule

// ----- sv/vbnr_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Resampler back end
// Owns the volume memory; reads four neighbors per sample and interpolates.
// ----------------------------------------------------------------------------
`include "volume_bilinear_nearest_resampler_defines.svh"
module vbnr_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                op_valid,
    output logic                op_stall,
    input  vbnr_pkg::op_t       op,
    output logic                valid,
    input  logic                stall,
    output logic signed [15:0]  voxel_out
);
    localparam int Depth = 1 << vbnr_pkg::AW;

    typedef enum logic [6:0] {
        ST_IDLE = 7'b0000001,
        ST_RD1  = 7'b0000010,
        ST_RD2  = 7'b0000100,
        ST_RD3  = 7'b0001000,
        ST_MB   = 7'b0010000,
        ST_MUL  = 7'b0100000,
        ST_OUT  = 7'b1000000
    } state_t;

    logic [15:0] mem [Depth];
    logic [15:0] rd_reg;
    state_t      state_reg, state_next;
    vbnr_pkg::op_t cur_reg;
    logic [vbnr_pkg::AW-1:0] raddr;
    logic        ready, out_free, take, ren, wen;
    logic signed [15:0] v00_reg, v10_reg, v01_reg;
    logic signed [33:0] v0_reg, v1_reg;   // Q8.24
    logic signed [51:0] ph_reg, pl_reg;
    logic signed [17:0] fa, fb, fac, fbc;
    logic        ovalid_reg;
    logic signed [15:0] out_reg, res;

    // output register is free when empty or drained at this edge
    assign out_free = !ovalid_reg || !stall;
    // next command taken while idle or as the finished sample is stored
    assign ready    = (state_reg == ST_IDLE) || ((state_reg == ST_OUT) && out_free);
    assign take     = op_valid && ready;
    assign op_stall = !ready;
    assign wen  = take && op.is_load && !op.label;
    assign ren  = take && !op.is_load;

    always_comb
    begin
        unique case (state_reg)
            ST_IDLE, ST_OUT: raddr = op.addr_ll;
            ST_RD1:  raddr = cur_reg.addr_hl;
            ST_RD2:  raddr = cur_reg.addr_lh;
            default: raddr = cur_reg.addr_hh;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wen)
            mem[op.addr_ll] <= op.data;
        rd_reg <= mem[raddr];
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (ren) state_next = ST_RD1;
            ST_RD1:  state_next = ST_RD2;
            ST_RD2:  state_next = ST_RD3;
            ST_RD3:  state_next = ST_MB;
            ST_MB:   state_next = ST_MUL;
            ST_MUL:  state_next = ST_OUT;
            ST_OUT:  if (out_free) state_next = ren ? ST_RD1 : ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    assign fa  = $signed({2'b0, cur_reg.frac_a});
    assign fb  = $signed({2'b0, cur_reg.frac_b});
    assign fac = 18'sh10000 - fa;
    assign fbc = 18'sh10000 - fb;

    // rounding of the Q8.40 sum
    logic signed [52:0] v;
    logic        neg;
    logic [52:0] m, mr;
    always_comb
    begin
        v   = 53'(ph_reg) + 53'(pl_reg);
        neg = v[52];
        m   = neg ? 53'(-v) : v;
        if (cur_reg.label)
        begin
            mr = (m + (53'd1 << 39)) >> 40;
            if (!neg && mr > 53'd127)
                mr = 53'd127;
            if (neg && mr > 53'd128)
                mr = 53'd128;
            res = {mr[7:0], 8'd0};
            if (neg)
                res = -res;
        end
        else
        begin
            mr = (m + (53'd1 << 31)) >> 32;
            if (!neg && mr > 53'd32767)
                mr = 53'd32767;
            if (neg && mr > 53'd32768)
                mr = 53'd32768;
            res = neg ? 16'(-mr[16:0]) : mr[15:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
            cur_reg <= op;
        if (state_reg == ST_RD1)
            v00_reg <= rd_reg;
        if (state_reg == ST_RD2)
        begin
            v10_reg <= rd_reg;
        end
        if (state_reg == ST_RD3)
        begin
            v01_reg <= rd_reg;
            v0_reg  <= v00_reg * fac + v10_reg * fa;
        end
        if (state_reg == ST_MB)
        begin
            v1_reg <= v01_reg * fac + $signed(rd_reg) * fa;
        end
        if (state_reg == ST_OUT && out_free)
        begin
            out_reg <= res;
        end
    end

    // second axis products, valid from ST_OUT on
    always_ff @(posedge clk)
    begin
        ph_reg <= v0_reg * fbc;
        pl_reg <= v1_reg * fb;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_OUT && out_free)
                ovalid_reg <= 1'b1;
            else if (!stall)
                ovalid_reg <= 1'b0;
        end
    end

    assign valid     = ovalid_reg;
    assign voxel_out = out_reg;

    `VBNR_ASSERT_IMPL(a_back_onehot, clk, rst_n, 1'b1, $onehot(state_reg))
    `VBNR_ASSERT_NEXT(a_back_hold, clk, rst_n, valid && stall, valid && $stable(voxel_out))
    `VBNR_ASSERT_NEXT(a_back_wait, clk, rst_n, state_reg == ST_OUT && !out_free, state_reg == ST_OUT)
    `VBNR_ASSERT_NEXT(a_back_load, clk, rst_n, take && op.is_load, state_reg == ST_IDLE)
endmodule

// ----- sv/volume_bilinear_nearest_resampler.sv -----
`timescale 1ns / 1ps
// Volume resampler, bilinear in a plane and nearest across it.
// Input channel: valid/stall with command, coord_x/y/z and voxel_in. A load
//   transaction within range writes one voxel into the 32x32x32 store; a
//   sample transaction yields one voxel_out transaction, a load yields none.
// Output channel: valid_out/stall_out carrying voxel_out (signed Q8.8).
// Configuration: cfg_we/cfg_index/cfg_data, to be written only while idle;
// the user must keep to this, as the block does not enforce it. Front end
// (2 stages: multiply, clamp/address) feeds a 2-entry queue; the back end
// reads the four neighbors from the single-port store, one per cycle, then
// passes ST_MB (second first-axis blend), ST_MUL (second-axis products) and
// ST_OUT, in which the next command is already taken if the output register
// is free. A sample thus holds the back end from ST_RD1 to ST_OUT; a load is
// written as it is taken. Input transactions are accepted back to back while
// the queue has room. Reset clears control state and loads the register
// defaults; the store contents are undefined until written. When the receiver
// stalls, the result holds and the queue fills, after which the input stalls.
// ----------------------------------------------------------------------------
// Resampler top level
// Connects front end, command queue and back end with configuration regs.
// ----------------------------------------------------------------------------
module volume_bilinear_nearest_resampler (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               valid,
    output logic               stall,
    input  logic               command,
    input  logic [7:0]         coord_x,
    input  logic [7:0]         coord_y,
    input  logic [7:0]         coord_z,
    input  logic signed [15:0] voxel_in,
    output logic               valid_out,
    input  logic               stall_out,
    output logic signed [15:0] voxel_out,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [23:0]        cfg_data
);
    logic [5:0]  size_x_reg, size_y_reg, size_z_reg;
    logic [23:0] ratio_x_reg, ratio_y_reg, ratio_z_reg;
    logic [1:0]  nearest_reg;
    logic        label_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_x_reg  <= 6'd32;
            size_y_reg  <= 6'd32;
            size_z_reg  <= 6'd32;
            ratio_x_reg <= 24'd65536;
            ratio_y_reg <= 24'd65536;
            ratio_z_reg <= 24'd65536;
            nearest_reg <= 2'd2;
            label_reg   <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                vbnr_pkg::REG_SIZE_X:  size_x_reg  <= cfg_data[5:0];
                vbnr_pkg::REG_SIZE_Y:  size_y_reg  <= cfg_data[5:0];
                vbnr_pkg::REG_SIZE_Z:  size_z_reg  <= cfg_data[5:0];
                vbnr_pkg::REG_RATIO_X: ratio_x_reg <= cfg_data;
                vbnr_pkg::REG_RATIO_Y: ratio_y_reg <= cfg_data;
                vbnr_pkg::REG_RATIO_Z: ratio_z_reg <= cfg_data;
                vbnr_pkg::REG_NEAREST: nearest_reg <= cfg_data[1:0];
                vbnr_pkg::REG_LABEL:   label_reg   <= cfg_data[0];
                default: ;
            endcase
        end
    end

    logic          f_valid, f_stall, b_valid, b_stall;
    vbnr_pkg::op_t f_op, b_op;

    vbnr_front u_front (
        .clk(clk), .rst_n(rst_n), .valid(valid), .stall(stall),
        .command(command), .coord_x(coord_x), .coord_y(coord_y),
        .coord_z(coord_z), .voxel_in(voxel_in),
        .src_size_x(size_x_reg), .src_size_y(size_y_reg), .src_size_z(size_z_reg),
        .ratio_x(ratio_x_reg), .ratio_y(ratio_y_reg), .ratio_z(ratio_z_reg),
        .nearest_axis(nearest_reg), .label_mode(label_reg),
        .op_valid(f_valid), .op(f_op), .op_stall(f_stall)
    );

    vbnr_queue u_queue (
        .clk(clk), .rst_n(rst_n),
        .in_valid(f_valid), .in_stall(f_stall), .in_op(f_op),
        .out_valid(b_valid), .out_stall(b_stall), .out_op(b_op)
    );

    vbnr_back u_back (
        .clk(clk), .rst_n(rst_n),
        .op_valid(b_valid), .op_stall(b_stall), .op(b_op),
        .valid(valid_out), .stall(stall_out), .voxel_out(voxel_out)
    );
endmodule

// ----- test/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Volume resampler testbench
// Loads small source regions, resamples them under many register settings
// and checks every voxel_out against an in-bench interpolator or a typed value.
// ----------------------------------------------------------------------------
module testbench;
    localparam int CYCLE_LIMIT = 600000;
    localparam int DRAIN_CYCLES = 20;   // back end latency plus margin
    localparam int PHASES = 12;
    localparam int SAMPLES_PER_PHASE = 40;

    logic               clk;
    logic               rst_n;
    logic               valid;
    logic               stall;
    logic               command;
    logic [7:0]         coord_x;
    logic [7:0]         coord_y;
    logic [7:0]         coord_z;
    logic signed [15:0] voxel_in;
    logic               valid_out;
    logic               stall_out;
    logic signed [15:0] voxel_out;
    logic               cfg_we;
    logic [2:0]         cfg_index;
    logic [23:0]        cfg_data;

    volume_bilinear_nearest_resampler dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .valid     (valid),
        .stall     (stall),
        .command   (command),
        .coord_x   (coord_x),
        .coord_y   (coord_y),
        .coord_z   (coord_z),
        .voxel_in  (voxel_in),
        .valid_out (valid_out),
        .stall_out (stall_out),
        .voxel_out (voxel_out),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Shadow of the block: voxel store, written map and register copies.
    logic signed [15:0] src_voxels [vbnr_pkg::MaxDimX*vbnr_pkg::MaxDimY*vbnr_pkg::MaxDimZ];
    bit                 voxel_known [vbnr_pkg::MaxDimX*vbnr_pkg::MaxDimY*vbnr_pkg::MaxDimZ];
    logic [5:0]         size_reg [3];
    logic [23:0]        ratio_reg [3];
    logic [1:0]         nearest_reg;
    logic               label_reg;

    logic [15:0] expected_voxels [$];
    int          mismatches;
    int          accepted_items;
    int          cycles;
    bit          long_hold;
    bit          hold_go;       // starts the long receiver hold
    bit          calm;          // stretch with no idling on either side

    typedef struct {
        logic        cmd;
        logic [7:0]  x, y, z;
        logic [15:0] value;
        bit          typed;     // expected value given by hand
        logic [15:0] result;
    } stim_row_t;

    // Hand-written opening sequence, run with sizes 2x2x1 at unit ratio.
    stim_row_t directed [15] = '{
        '{vbnr_pkg::CMD_LOAD,   8'd0,   8'd0,   8'd0,   16'h7FFF, 1'b0, 16'h0000},
        '{vbnr_pkg::CMD_LOAD,   8'd1,   8'd0,   8'd0,   16'h8000, 1'b0, 16'h0000},
        '{vbnr_pkg::CMD_LOAD,   8'd0,   8'd1,   8'd0,   16'h0100, 1'b0, 16'h0000},
        '{vbnr_pkg::CMD_LOAD,   8'd1,   8'd1,   8'd0,   16'hFF00, 1'b0, 16'h0000},
        // loads beyond the store are dropped
        '{vbnr_pkg::CMD_LOAD,   8'd32,  8'd0,   8'd0,   16'h1234, 1'b0, 16'h0000},
        '{vbnr_pkg::CMD_LOAD,   8'd0,   8'd40,  8'd0,   16'h1234, 1'b0, 16'h0000},
        '{vbnr_pkg::CMD_LOAD,   8'd0,   8'd0,   8'd32,  16'h1234, 1'b0, 16'h0000},
        '{vbnr_pkg::CMD_LOAD,   8'd255, 8'd255, 8'd255, 16'h5555, 1'b0, 16'h0000},
        '{vbnr_pkg::CMD_SAMPLE, 8'd0,   8'd0,   8'd0,   16'h0000, 1'b1, 16'h7FFF},
        '{vbnr_pkg::CMD_SAMPLE, 8'd1,   8'd0,   8'd0,   16'hAAAA, 1'b1, 16'h8000},
        '{vbnr_pkg::CMD_SAMPLE, 8'd0,   8'd1,   8'd0,   16'h0000, 1'b1, 16'h0100},
        '{vbnr_pkg::CMD_SAMPLE, 8'd1,   8'd1,   8'd0,   16'h0000, 1'b1, 16'hFF00},
        // clamped on every axis
        '{vbnr_pkg::CMD_SAMPLE, 8'd255, 8'd255, 8'd255, 16'h0000, 1'b1, 16'hFF00},
        '{vbnr_pkg::CMD_SAMPLE, 8'd0,   8'd0,   8'd200, 16'h0000, 1'b1, 16'h7FFF},
        '{vbnr_pkg::CMD_SAMPLE, 8'd128, 8'd0,   8'd1,   16'h0000, 1'b0, 16'h0000}
    };

    function automatic int eff_size(input int ax);
        int s;
        s = size_reg[ax];
        if (s == 0)
            s = 1;
        if (s > vbnr_pkg::MaxDimX)
            s = vbnr_pkg::MaxDimX;
        return s;
    endfunction

    function automatic longint fetch_voxel(input int c[3]);
        return longint'(src_voxels[(c[0] * vbnr_pkg::MaxDimY + c[1]) * vbnr_pkg::MaxDimZ
                                   + c[2]]);
    endfunction

    // round to nearest, ties away from zero
    function automatic longint round_away(input longint v, input int sh);
        longint m;
        m = (v < 0) ? -v : v;
        m = (m + (longint'(1) << (sh - 1))) >> sh;
        return (v < 0) ? -m : m;
    endfunction

    function automatic logic [15:0] resample_voxel(input logic [7:0] cx, cy, cz);
        logic [7:0] crd [3];
        int n, a, b, sz;
        int lo [3];
        int hi [3];
        int c [3];
        longint fr [3];
        longint unsigned p;
        longint v00, v10, v01, v11, v0, v1, v, r;
        crd[0] = cx; crd[1] = cy; crd[2] = cz;
        n = (nearest_reg >= 2) ? 2 : int'(nearest_reg);
        a = (n + 1) % 3;
        b = (n + 2) % 3;
        for (int ax = 0; ax < 3; ax++)
        begin
            p = longint'(crd[ax]) * longint'(ratio_reg[ax]);
            sz = eff_size(ax);
            fr[ax] = 0;
            if (ax == n)
            begin
                lo[ax] = ((p + 32768) >> 16) > sz - 1 ? sz - 1 : int'((p + 32768) >> 16);
                hi[ax] = lo[ax];
            end
            else if ((p >> 16) >= sz - 1)
            begin
                lo[ax] = sz - 1;
                hi[ax] = lo[ax];
            end
            else
            begin
                lo[ax] = int'(p >> 16);
                hi[ax] = lo[ax] + 1;
                fr[ax] = p & 64'hFFFF;
            end
        end
        c[n] = lo[n];
        c[a] = lo[a]; c[b] = lo[b]; v00 = fetch_voxel(c);
        c[a] = hi[a]; c[b] = lo[b]; v10 = fetch_voxel(c);
        c[a] = lo[a]; c[b] = hi[b]; v01 = fetch_voxel(c);
        c[a] = hi[a]; c[b] = hi[b]; v11 = fetch_voxel(c);
        v0 = v00 * (65536 - fr[a]) + v10 * fr[a];
        v1 = v01 * (65536 - fr[a]) + v11 * fr[a];
        v = v0 * (65536 - fr[b]) + v1 * fr[b];
        if (label_reg)
        begin
            r = round_away(v, 40);
            if (r > 127)
                r = 127;
            if (r < -128)
                r = -128;
            r = r * 256;
        end
        else
        begin
            r = round_away(v, 32);
            if (r > 32767)
                r = 32767;
            if (r < -32768)
                r = -32768;
        end
        return r[15:0];
    endfunction

    // Clock and watchdog.
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // Receiver: random stall per transaction, forced high during long_hold.
    // Every accepted voxel_out is checked against the oldest expectation.
    initial
    begin : receiver
        int wait_left;
        logic [15:0] want;
        wait_left = 0;
        stall_out = 1'b1;
        forever
        begin
            @(posedge clk);
            if (rst_n && valid_out && !stall_out)
            begin
                if (expected_voxels.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected voxel_out %h", voxel_out);
                end
                else
                begin
                    want = expected_voxels.pop_front();
                    if (voxel_out !== want)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("voxel_out mismatch: expected %h got %h", want, voxel_out);
                    end
                end
                wait_left = calm ? 0 : $urandom_range(0, 16);
            end
            stall_out <= long_hold || (wait_left > 0);
            if (wait_left > 0)
                wait_left--;
        end
    end

    // Long hold during the samples of the third phase, so the internal
    // queue fills and the input side stalls.
    initial
    begin
        long_hold = 1'b0;
        wait (hold_go);
        @(posedge clk);
        long_hold <= 1'b1;
        repeat (400) @(posedge clk);
        long_hold <= 1'b0;
    end

    // One input transaction: idle gap, offer, wait for acceptance, predict.
    task automatic send_item(input logic cmd, input logic [7:0] x, y, z,
                             input logic [15:0] value, input bit typed,
                             input logic [15:0] result);
        int gap;
        int addr;
        gap = calm ? 0 : $urandom_range(0, 16);
        if (gap > 0)
        begin
            valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        valid <= 1'b1;
        command <= cmd;
        coord_x <= x;
        coord_y <= y;
        coord_z <= z;
        voxel_in <= value;
        do
            @(posedge clk);
        while (stall);
        accepted_items++;
        if (cmd == vbnr_pkg::CMD_LOAD)
        begin
            if (x < vbnr_pkg::MaxDimX && y < vbnr_pkg::MaxDimY && z < vbnr_pkg::MaxDimZ)
            begin
                addr = (x * vbnr_pkg::MaxDimY + y) * vbnr_pkg::MaxDimZ + z;
                src_voxels[addr] = value;
                voxel_known[addr] = 1'b1;
            end
        end
        else
            expected_voxels.push_back(typed ? result : resample_voxel(x, y, z));
    endtask

    // Wait until idle, then write all eight registers.
    task automatic write_config(input logic [5:0] sx, sy, sz,
                                input logic [23:0] rx, ry, rz,
                                input logic [1:0] near, input logic lbl);
        logic [23:0] vals [8];
        valid <= 1'b0;
        while (expected_voxels.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        vals[vbnr_pkg::REG_SIZE_X] = 24'(sx);
        vals[vbnr_pkg::REG_SIZE_Y] = 24'(sy);
        vals[vbnr_pkg::REG_SIZE_Z] = 24'(sz);
        vals[vbnr_pkg::REG_RATIO_X] = rx;
        vals[vbnr_pkg::REG_RATIO_Y] = ry;
        vals[vbnr_pkg::REG_RATIO_Z] = rz;
        vals[vbnr_pkg::REG_NEAREST] = 24'(near);
        vals[vbnr_pkg::REG_LABEL] = 24'(lbl);
        for (int i = 0; i < 8; i++)
        begin
            cfg_we <= 1'b1;
            cfg_index <= i[2:0];
            cfg_data <= vals[i];
            @(posedge clk);
        end
        cfg_we <= 1'b0;
        size_reg[0] = sx; size_reg[1] = sy; size_reg[2] = sz;
        ratio_reg[0] = rx; ratio_reg[1] = ry; ratio_reg[2] = rz;
        nearest_reg = near;
        label_reg = lbl;
    endtask

    function automatic logic [15:0] pick_value();
        case ($urandom_range(0, 5))
            0: return 16'h7FFF;
            1: return 16'h8000;
            default: return 16'($urandom());
        endcase
    endfunction

    function automatic logic [23:0] pick_ratio();
        case ($urandom_range(0, 5))
            0: return 24'd0;
            1: return 24'hFFFFFF;
            2: return 24'h010000;
            3: return 24'($urandom_range(0, 24'h020000));
            4: return 24'($urandom_range(24'h4000, 24'h00C000));
            default: return 24'($urandom());
        endcase
    endfunction

    // Coordinate that mostly lands inside the region so neighbors interpolate.
    function automatic logic [7:0] pick_coord(input int ax);
        longint top;
        if ($urandom_range(0, 3) == 0 || ratio_reg[ax] == 0)
            return 8'($urandom());
        top = (longint'(eff_size(ax)) * 65536) / ratio_reg[ax];
        if (top > 255)
            top = 255;
        return 8'($urandom_range(0, int'(top)));
    endfunction

    initial
    begin : stimulus
        logic [5:0] sz [3];
        int big;
        rst_n = 1'b0;
        valid = 1'b0;
        command = vbnr_pkg::CMD_LOAD;
        coord_x = '0;
        coord_y = '0;
        coord_z = '0;
        voxel_in = '0;
        cfg_we = 1'b0;
        cfg_index = vbnr_pkg::REG_SIZE_X;
        cfg_data = '0;
        calm = 1'b0;
        hold_go = 1'b0;
        mismatches = 0;
        accepted_items = 0;
        cycles = 0;
        for (int i = 0; i < vbnr_pkg::MaxDimX * vbnr_pkg::MaxDimY * vbnr_pkg::MaxDimZ; i++)
        begin
            src_voxels[i] = '0;
            voxel_known[i] = 1'b0;
        end
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_config(6'd2, 6'd2, 6'd1, 24'h010000, 24'h010000, 24'h010000, 2'd2, 1'b0);
        foreach (directed[i])
            send_item(directed[i].cmd, directed[i].x, directed[i].y, directed[i].z,
                      directed[i].value, directed[i].typed, directed[i].result);

        for (int ph = 0; ph < PHASES; ph++)
        begin
            // register extremes first, then random small regions
            if (ph == 0)
                write_config(6'd63, 6'd1, 6'd0, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF,
                             2'd3, 1'b1);
            else if (ph == 1)
                write_config(6'd1, 6'd32, 6'd2, 24'd0, 24'd0, 24'd0, 2'd0, 1'b0);
            else
            begin
                big = $urandom_range(0, 5);
                for (int ax = 0; ax < 3; ax++)
                    sz[ax] = (big == ax) ? 6'($urandom_range(32, 63))
                           : (big < 3) ? 6'($urandom_range(0, 1))
                           : 6'($urandom_range(0, 5));
                write_config(sz[0], sz[1], sz[2], pick_ratio(), pick_ratio(), pick_ratio(),
                             2'($urandom_range(0, 3)), 1'($urandom()));
            end
            calm = ($urandom_range(0, 3) == 0);

            // fill the active region where it was never written
            for (int x = 0; x < eff_size(0); x++)
                for (int y = 0; y < eff_size(1); y++)
                    for (int z = 0; z < eff_size(2); z++)
                        if (!voxel_known[(x * vbnr_pkg::MaxDimY + y) * vbnr_pkg::MaxDimZ + z])
                            send_item(vbnr_pkg::CMD_LOAD, 8'(x), 8'(y), 8'(z),
                                      pick_value(), 1'b0, '0);

            if (ph == 2)
                hold_go = 1'b1;

            // samples mixed with in-region rewrites and dropped loads
            for (int k = 0; k < SAMPLES_PER_PHASE; k++)
            begin
                case ($urandom_range(0, 9))
                    0: send_item(vbnr_pkg::CMD_LOAD, 8'($urandom_range(0, eff_size(0) - 1)),
                                 8'($urandom_range(0, eff_size(1) - 1)),
                                 8'($urandom_range(0, eff_size(2) - 1)),
                                 pick_value(), 1'b0, '0);
                    1: send_item(vbnr_pkg::CMD_LOAD, 8'($urandom_range(32, 255)),
                                 8'($urandom()), 8'($urandom()), pick_value(), 1'b0, '0);
                    default: send_item(vbnr_pkg::CMD_SAMPLE, pick_coord(0), pick_coord(1),
                                       pick_coord(2), 16'($urandom()), 1'b0, '0);
                endcase
            end
        end

        valid <= 1'b0;
        while (expected_voxels.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule
